>>> hw/rtl/rv32ie_pkg.sv
`timescale 1ns / 1ps

package rv32ie_pkg;

  localparam int unsigned MEM_BYTES_DEF = 1048576;
  localparam int unsigned REG_COUNT     = 32;
  localparam logic [31:0] HALT_WORD     = 32'h0ff00513;
  localparam logic [4:0]  REG_A0        = 5'd10;

  // opcodes
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // load / store funct3
  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

  // alu funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_EXEC    = 3'd1,
    ST_HALT    = 3'd2,
    ST_ILLEGAL = 3'd3,
    ST_STOPPED = 3'd4
  } status_t;

  typedef struct packed {
    logic        ok;
    logic        wb;
    logic        ld;
    logic        st;
    logic [31:0] res;
    logic [31:0] npc;
    logic [31:0] addr;
  } exec_t;

endpackage

>>> hw/rtl/rv32ie_mem.sv
`timescale 1ns / 1ps

module rv32ie_mem #(
  parameter int unsigned MEM_BYTES = rv32ie_pkg::MEM_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  output logic                                busy,
  input  logic [3:0][$clog2(MEM_BYTES)-3:0]   rd_row,
  output logic [3:0][7:0]                     rd_data,
  input  logic [3:0]                          wr_en,
  input  logic [3:0][$clog2(MEM_BYTES)-3:0]   wr_row,
  input  logic [3:0][7:0]                     wr_data
);
  import rv32ie_pkg::*;

  localparam int unsigned AW   = $clog2(MEM_BYTES);
  localparam int unsigned RW   = AW - 2;
  localparam int unsigned ROWS = MEM_BYTES / 4;

  logic [RW-1:0] clr_row;

  // clearing sweep, one row of all four banks per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + RW'(1);
      if (clr_row == RW'(ROWS - 1)) busy <= 1'b0;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0] bank [ROWS];
    always_ff @(posedge clk) begin
      if (busy) begin
        bank[clr_row] <= 8'h00;
      end else if (wr_en[k]) begin
        bank[wr_row[k]] <= wr_data[k];
      end
      rd_data[k] <= bank[rd_row[k]];
    end
  end

endmodule

>>> hw/rtl/rv32ie_regfile.sv
`timescale 1ns / 1ps

module rv32ie_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  ra_addr,
  input  logic [4:0]  rb_addr,
  output logic [31:0] ra_data,
  output logic [31:0] rb_data,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [31:0] wd
);
  import rv32ie_pkg::*;

  logic [31:0]          regs [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic [31:0]          ra_q;
  logic [31:0]          rb_q;
  logic                 va_q;
  logic                 vb_q;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) regs[wa] <= wd;
    ra_q <= regs[ra_addr];
    rb_q <= regs[rb_addr];
    va_q <= valid[ra_addr];
    vb_q <= valid[rb_addr];
  end

  assign ra_data = va_q ? ra_q : 32'h0;
  assign rb_data = vb_q ? rb_q : 32'h0;

endmodule

>>> hw/rtl/rv32ie_alu.sv
`timescale 1ns / 1ps

module rv32ie_alu (
  input  logic [31:0]        w,
  input  logic [31:0]        pc,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output rv32ie_pkg::exec_t  x
);
  import rv32ie_pkg::*;

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [31:0] immi;
  logic [31:0] imms;
  logic [31:0] immb;
  logic [31:0] immj;
  logic [31:0] o2;
  logic [4:0]  shamt;
  logic        taken;
  logic        is_reg;

  assign op     = w[6:0];
  assign f3     = w[14:12];
  assign immi   = {{20{w[31]}}, w[31:20]};
  assign imms   = {{20{w[31]}}, w[31:25], w[11:7]};
  assign immb   = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign immj   = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign is_reg = (op == OP_REG);
  assign o2     = is_reg ? b : immi;
  assign shamt  = o2[4:0];

  always_comb begin
    x       = '0;
    x.ok    = 1'b1;
    x.npc   = pc + 32'd4;
    taken   = 1'b0;
    case (op)
      OP_LUI: begin
        x.wb  = 1'b1;
        x.res = {w[31:12], 12'h000};
      end
      OP_AUIPC: begin
        x.wb  = 1'b1;
        x.res = pc + {w[31:12], 12'h000};
      end
      OP_JAL: begin
        x.wb  = 1'b1;
        x.res = pc + 32'd4;
        x.npc = pc + immj;
      end
      OP_JALR: begin
        x.wb  = 1'b1;
        x.res = pc + 32'd4;
        x.npc = (a + immi) & ~32'd1;
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  taken = (a == b);
          F3_BNE:  taken = (a != b);
          F3_BLT:  taken = ($signed(a) < $signed(b));
          F3_BGE:  taken = !($signed(a) < $signed(b));
          F3_BLTU: taken = (a < b);
          F3_BGEU: taken = (a >= b);
          default: x.ok = 1'b0;
        endcase
        if (taken) x.npc = pc + immb;
      end
      OP_STORE: begin
        x.addr = a + imms;
        if (f3 == F3_B || f3 == F3_H || f3 == F3_W) x.st = 1'b1;
        else x.ok = 1'b0;
      end
      OP_LOAD: begin
        x.addr = a + immi;
        case (f3)
          F3_B, F3_H, F3_W, F3_BU, F3_HU: x.ld = 1'b1;
          default: x.ok = 1'b0;
        endcase
      end
      OP_IMM, OP_REG: begin
        x.wb = 1'b1;
        case (f3)
          F3_ADD:  x.res = (is_reg && w[30]) ? a - o2 : a + o2;
          F3_SLL:  x.res = a << shamt;
          F3_SLT:  x.res = {31'd0, $signed(a) < $signed(o2)};
          F3_SLTU: x.res = {31'd0, a < o2};
          F3_XOR:  x.res = a ^ o2;
          F3_SR:   x.res = w[30] ? 32'($signed(a) >>> shamt) : a >> shamt;
          F3_OR:   x.res = a | o2;
          F3_AND:  x.res = a & o2;
          default: x.res = a & o2;
        endcase
      end
      default: x.ok = 1'b0;
    endcase
    if (!x.ok) begin
      x.wb  = 1'b0;
      x.ld  = 1'b0;
      x.st  = 1'b0;
      x.npc = pc;
    end
  end

endmodule

>>> hw/rtl/rv32i_instruction_executor_core.sv
`timescale 1ns / 1ps
// rv32i base integer core over a byte-addressed little-endian memory
// input channel (in_valid/in_ready): action 0 writes load_byte at load_address
// (taken modulo MEM_BYTES), action 1 executes the instruction at the pc
// output channel (out_valid/out_ready): one result transaction per input
// transaction: status, executed_pc, instruction_word, next_pc, exit_code
// a byte write returns its result in the cycle after acceptance and a new
// write can be taken every cycle while out_ready is high; an instruction goes
// through fetch read, register read and execute, and a load adds a data memory read
// the next instruction is only accepted once the previous one has retired,
// since its fetch address is the pc that the previous one leaves
// memory is four byte banks with synchronous reads, so any four
// consecutive bytes (misaligned too) come out in one access
// reset: pc, registers and the stopped flag clear at once; then a sweep
// clears the memory, with in_ready held low
// stall: a finished result sits in the output register; new transactions
// are taken while out_ready is high or the register is empty
module rv32i_instruction_executor_core #(
  parameter int unsigned MEM_BYTES = rv32ie_pkg::MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [19:0] load_address,
  input  logic [7:0]  load_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] executed_pc,
  output logic [31:0] instruction_word,
  output logic [31:0] next_pc,
  output logic [7:0]  exit_code
);
  import rv32ie_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam int unsigned RW = AW - 2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EXEC  = 4'b0100,
    S_MEM   = 4'b1000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [31:0]   pc;
  logic          stopped;
  logic [31:0]   ir;
  logic [AW-1:0] ld_addr;
  status_t       out_status;

  logic              accept;
  logic              mem_busy;
  logic [3:0][RW-1:0] rd_row;
  logic [3:0][7:0]   rd_data;
  logic [3:0]        wr_en;
  logic [3:0][RW-1:0] wr_row;
  logic [3:0][7:0]   wr_data;
  logic [AW-1:0]     rd_base;
  logic [AW-1:0]     la;
  logic [AW-1:0]     st_addr;
  logic [31:0]       wfetch;
  logic [31:0]       ldword;
  logic [31:0]       ld_val;
  logic [4:0]        ra_addr;
  logic [4:0]        rb_addr;
  logic [31:0]       ra_data;
  logic [31:0]       rb_data;
  logic              rf_we;
  logic [4:0]        rf_wa;
  logic [31:0]       rf_wd;
  logic              is_halt;
  exec_t             x;
  logic [1:0]        bi;
  logic [1:0]        lim;

  // an item is taken only when the core is idle and the result slot frees up
  assign in_ready = (state == S_IDLE) && !mem_busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign la       = AW'(load_address);
  assign is_halt  = (ir == HALT_WORD);
  assign st_addr  = x.addr[AW-1:0];

  rv32ie_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .busy    (mem_busy),
    .rd_row  (rd_row),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_row  (wr_row),
    .wr_data (wr_data)
  );

  rv32ie_regfile u_rf (
    .clk     (clk),
    .rst     (rst),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data),
    .we      (rf_we),
    .wa      (rf_wa),
    .wd      (rf_wd)
  );

  rv32ie_alu u_alu (
    .w  (ir),
    .pc (pc),
    .a  (ra_data),
    .b  (rb_data),
    .x  (x)
  );

  // memory reads: instruction fetch from idle, data load from execute;
  // bank k holds the byte of the 4-byte window whose low two bits are k
  assign rd_base = (state == S_EXEC) ? st_addr : pc[AW-1:0];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_row[k] = rd_base[AW-1:2] + RW'(2'(k) < rd_base[1:0]);
    end
  end

  // reassemble the fetched word and the loaded word in byte order
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wfetch[8*i +: 8] = rd_data[2'(pc[1:0] + 2'(i))];
      ldword[8*i +: 8] = rd_data[2'(ld_addr[1:0] + 2'(i))];
    end
  end

  always_comb begin
    case (ir[14:12])
      F3_B:    ld_val = {{24{ldword[7]}}, ldword[7:0]};
      F3_H:    ld_val = {{16{ldword[15]}}, ldword[15:0]};
      F3_BU:   ld_val = {24'd0, ldword[7:0]};
      F3_HU:   ld_val = {16'd0, ldword[15:0]};
      default: ld_val = ldword;
    endcase
  end

  // register reads are issued as the fetched word arrives; the halt word
  // reads a0 on the second port for the exit code
  assign ra_addr = wfetch[19:15];
  assign rb_addr = (wfetch == HALT_WORD) ? REG_A0 : wfetch[24:20];

  // register writeback: alu results in execute, load data in the following memory state
  always_comb begin
    rf_we = 1'b0;
    rf_wa = ir[11:7];
    rf_wd = x.res;
    if (state == S_EXEC && !is_halt && x.wb && !x.ld && ir[11:7] != 5'd0) begin
      rf_we = 1'b1;
    end else if (state == S_MEM && ir[11:7] != 5'd0) begin
      rf_we = 1'b1;
      rf_wd = ld_val;
    end
  end

  // memory writes: program byte from the input, or a store of 1, 2 or 4 bytes
  always_comb begin
    wr_en   = '0;
    wr_row  = '0;
    wr_data = '0;
    lim     = 2'd0;
    bi      = 2'd0;
    if (accept && !action) begin
      wr_en[la[1:0]]   = 1'b1;
      wr_row[la[1:0]]  = la[AW-1:2];
      wr_data[la[1:0]] = load_byte;
    end else if (state == S_EXEC && !is_halt && x.st) begin
      case (ir[14:12])
        F3_B:    lim = 2'd0;
        F3_H:    lim = 2'd1;
        default: lim = 2'd3;
      endcase
      for (int k = 0; k < 4; k++) begin
        bi         = 2'(2'(k) - st_addr[1:0]);
        wr_en[k]   = (bi <= lim);
        wr_row[k]  = st_addr[AW-1:2] + RW'(2'(k) < st_addr[1:0]);
        wr_data[k] = rb_data[8*bi +: 8];
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept && action && !stopped) state_next = S_FETCH;
      S_FETCH: state_next = S_EXEC;
      S_EXEC:  state_next = (!is_halt && x.ld) ? S_MEM : S_IDLE;
      S_MEM:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= 32'h0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (!action || stopped)) out_valid <= 1'b1;
        end
        S_EXEC: begin
          if (is_halt) begin
            pc        <= pc + 32'd4;
            stopped   <= 1'b1;
            out_valid <= 1'b1;
          end else if (!x.ld) begin
            pc        <= x.npc;
            stopped   <= !x.ok;
            out_valid <= 1'b1;
          end
        end
        S_MEM: begin
          pc        <= pc + 32'd4;
          out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          out_status       <= !action ? ST_LOADED : ST_STOPPED;
          executed_pc      <= !action ? 32'h0 : pc;
          instruction_word <= 32'h0;
          next_pc          <= pc;
          exit_code        <= 8'h00;
        end
      end
      S_FETCH: begin
        ir <= wfetch;
      end
      S_EXEC: begin
        ld_addr          <= st_addr;
        executed_pc      <= pc;
        instruction_word <= ir;
        if (is_halt) begin
          out_status <= ST_HALT;
          next_pc    <= pc + 32'd4;
          exit_code  <= rb_data[7:0];
        end else begin
          out_status <= x.ok ? ST_EXEC : ST_ILLEGAL;
          next_pc    <= x.npc;
          exit_code  <= 8'h00;
        end
      end
      S_MEM: begin
        out_status <= ST_EXEC;
        next_pc    <= pc + 32'd4;
      end
      default: begin
      end
    endcase
  end

  assign status = out_status;

`ifndef SYNTHESIS
  // nothing is taken while the memory sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    mem_busy |-> !in_ready)
    else $error("input accepted during memory clear");

  // a stopped or illegal result leaves the pc where it was
  a_stop_pc: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_STOPPED || out_status == ST_ILLEGAL)
      |-> next_pc == executed_pc)
    else $error("pc moved on a stopped or illegal result");

  // a halt result carries the halt word
  a_halt_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_HALT |-> instruction_word == HALT_WORD)
    else $error("halt status without the halt word");

  // an illegal or halt result always stops the core
  a_stop_sets: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && (is_halt || !x.ok) |=> stopped)
    else $error("core not stopped after halt or illegal instruction");

  // result register is free while an instruction is in its fetch state
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH |-> !out_valid)
    else $error("result pending while an instruction executes");
`endif

endmodule

>>> tb/rv32i_executor_checker.sv
`timescale 1ns / 1ps

module rv32i_executor_checker #(
  parameter int unsigned MEM_BYTES = rv32ie_pkg::MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        action,
  input  logic [19:0] load_address,
  input  logic [7:0]  load_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [31:0] executed_pc,
  input  logic [31:0] instruction_word,
  input  logic [31:0] next_pc,
  input  logic [7:0]  exit_code,
  output int          errors,
  output int          pending
);
  import rv32ie_pkg::*;

  typedef struct {
    status_t     st;
    logic [31:0] epc;
    logic [31:0] iw;
    logic [31:0] npc;
    logic [7:0]  ex;
  } step_result_t;

  step_result_t awaited_results[$];

  logic [7:0]  mem_image [MEM_BYTES];
  logic [31:0] gpr [REG_COUNT];
  logic [31:0] pc;
  logic        stopped;

  initial begin
    errors  = 0;
    pending = 0;
    foreach (mem_image[i]) mem_image[i] = 8'h00;
  end

  function automatic logic [31:0] mem_read(input logic [31:0] addr, input int n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++)
      v |= 32'(mem_image[(addr + i) % MEM_BYTES]) << (8 * i);
    return v;
  endfunction

  task automatic mem_write(input logic [31:0] addr, input logic [31:0] data, input int n);
    for (int i = 0; i < n; i++)
      mem_image[(addr + i) % MEM_BYTES] = data[8*i +: 8];
  endtask

  // one transaction through the architectural state
  task automatic execute_transaction(input logic act, input logic [19:0] la,
                                     input logic [7:0] lb, output step_result_t r);
    logic [31:0] w, npc, a, b, res, addr, o2;
    logic [31:0] immi, imms, immb, immj;
    logic        legal, wb, reg_op, taken;
    r.st  = ST_LOADED;
    r.epc = '0;
    r.iw  = '0;
    r.ex  = '0;
    r.npc = pc;
    if (!act) begin
      mem_image[la % MEM_BYTES] = lb;
    end else if (stopped) begin
      r.st  = ST_STOPPED;
      r.epc = pc;
    end else begin
      w     = mem_read(pc, 4);
      npc   = pc + 32'd4;
      a     = gpr[w[19:15]];
      b     = gpr[w[24:20]];
      immi  = {{20{w[31]}}, w[31:20]};
      imms  = {{20{w[31]}}, w[31:25], w[11:7]};
      immb  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      immj  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      legal = 1'b1;
      wb    = 1'b0;
      res   = '0;
      r.st  = ST_EXEC;
      if (w == HALT_WORD) begin
        r.st    = ST_HALT;
        r.ex    = gpr[REG_A0][7:0];
        stopped = 1'b1;
      end else begin
        case (w[6:0])
          OP_LUI:   begin res = {w[31:12], 12'h000}; wb = 1'b1; end
          OP_AUIPC: begin res = pc + {w[31:12], 12'h000}; wb = 1'b1; end
          OP_JAL:   begin res = pc + 32'd4; wb = 1'b1; npc = pc + immj; end
          OP_JALR:  begin res = pc + 32'd4; wb = 1'b1; npc = (a + immi) & ~32'd1; end
          OP_BRANCH: begin
            taken = 1'b0;
            case (w[14:12])
              F3_BEQ:  taken = (a == b);
              F3_BNE:  taken = (a != b);
              F3_BLT:  taken = ($signed(a) < $signed(b));
              F3_BGE:  taken = !($signed(a) < $signed(b));
              F3_BLTU: taken = (a < b);
              F3_BGEU: taken = (a >= b);
              default: legal = 1'b0;
            endcase
            if (legal && taken) npc = pc + immb;
          end
          OP_STORE: begin
            addr = a + imms;
            case (w[14:12])
              F3_B:    mem_write(addr, b, 1);
              F3_H:    mem_write(addr, b, 2);
              F3_W:    mem_write(addr, b, 4);
              default: legal = 1'b0;
            endcase
          end
          OP_LOAD: begin
            addr = a + immi;
            wb   = 1'b1;
            case (w[14:12])
              F3_B:    begin res = mem_read(addr, 1); res = {{24{res[7]}}, res[7:0]}; end
              F3_H:    begin res = mem_read(addr, 2); res = {{16{res[15]}}, res[15:0]}; end
              F3_W:    res = mem_read(addr, 4);
              F3_BU:   res = mem_read(addr, 1);
              F3_HU:   res = mem_read(addr, 2);
              default: legal = 1'b0;
            endcase
          end
          OP_IMM, OP_REG: begin
            reg_op = (w[6:0] == OP_REG);
            o2     = reg_op ? b : immi;
            wb     = 1'b1;
            case (w[14:12])
              F3_ADD:  res = (reg_op && w[30]) ? a - o2 : a + o2;
              F3_SLL:  res = a << o2[4:0];
              F3_SLT:  res = ($signed(a) < $signed(o2)) ? 32'd1 : 32'd0;
              F3_SLTU: res = (a < o2) ? 32'd1 : 32'd0;
              F3_XOR:  res = a ^ o2;
              F3_SR:   res = w[30] ? 32'($signed(a) >>> o2[4:0]) : a >> o2[4:0];
              F3_OR:   res = a | o2;
              default: res = a & o2;
            endcase
          end
          default: legal = 1'b0;
        endcase
        if (!legal) begin
          r.st    = ST_ILLEGAL;
          npc     = pc;
          wb      = 1'b0;
          stopped = 1'b1;
        end
        if (wb && w[11:7] != 5'd0) gpr[w[11:7]] = res;
      end
      r.epc = pc;
      r.iw  = w;
      r.npc = npc;
      pc    = npc;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%08h actual 0x%08h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    step_result_t exp_r, new_r;
    if (rst) begin
      foreach (gpr[i]) gpr[i] = '0;
      pc      = '0;
      stopped = 1'b0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with nothing outstanding");
          errors++;
        end else begin
          exp_r = awaited_results.pop_front();
          check_field("status", 32'(exp_r.st), 32'(status));
          check_field("executed_pc", exp_r.epc, executed_pc);
          check_field("instruction_word", exp_r.iw, instruction_word);
          check_field("next_pc", exp_r.npc, next_pc);
          check_field("exit_code", 32'(exp_r.ex), 32'(exit_code));
        end
      end
      if (in_valid && in_ready) begin
        execute_transaction(action, load_address, load_byte, new_r);
        awaited_results.push_back(new_r);
      end
    end
    pending = awaited_results.size();
  end

endmodule

>>> tb/tb_rv32i_instruction_executor_core.sv
`timescale 1ns / 1ps

module tb_rv32i_instruction_executor_core;
  import rv32ie_pkg::*;

  // cycles with no transaction on either side before giving up; covers the
  // memory clearing sweep after reset with margin
  localparam int IDLE_LIMIT = 1000000;
  localparam int RANDOM_INSNS = 230;

  // encodings the core must reject
  localparam logic [6:0] OP_UNKNOWN = 7'h0b;
  localparam logic [2:0] F3_BR_BAD  = 3'd2;
  localparam logic [2:0] F3_LD_BAD  = 3'd3;
  localparam logic [2:0] F3_ST_BAD  = 3'd3;

  localparam logic [2:0] BR_F3 [6] = '{F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU};
  localparam logic [2:0] LD_F3 [5] = '{F3_B, F3_H, F3_W, F3_BU, F3_HU};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [19:0] load_address;
  logic [7:0]  load_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [31:0] executed_pc;
  logic [31:0] instruction_word;
  logic [31:0] next_pc;
  logic [7:0]  exit_code;
  int          errors;
  int          pending;

  rv32i_instruction_executor_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .load_address(load_address), .load_byte(load_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .executed_pc(executed_pc), .instruction_word(instruction_word),
    .next_pc(next_pc), .exit_code(exit_code)
  );

  rv32i_executor_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .load_address(load_address), .load_byte(load_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .executed_pc(executed_pc), .instruction_word(instruction_word),
    .next_pc(next_pc), .exit_code(exit_code),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // transactions sent and results seen; the pc of the core is taken from
  // the next_pc of the last result so code can be written where it runs
  int          sent_count;
  int          result_count;
  logic [31:0] core_pc;
  logic [31:0] last_next_pc;
  int          burst_left;
  int          idle_cycles;

  always @(posedge clk) begin
    if (rst) begin
      result_count <= 0;
      last_next_pc <= '0;
    end else if (out_valid && out_ready) begin
      result_count <= result_count + 1;
      last_next_pc <= next_pc;
    end
  end

  // watchdog: no transaction at all for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver: stall behavior switches at random between modes
  int ready_mode;
  int ready_phase;
  always @(negedge clk) begin
    if (ready_phase == 0) begin
      ready_mode  = $urandom_range(0, 3);
      ready_phase = $urandom_range(20, 200);
    end else begin
      ready_phase--;
    end
    case (ready_mode)
      0:       out_ready = 1'b1;                         // no stalls
      1:       out_ready = 1'($urandom_range(0, 1));     // coin flip
      2:       out_ready = ($urandom_range(0, 9) == 0);  // mostly stalled
      default: out_ready = ready_phase[3];               // alternating equal on and off runs
    endcase
  end

  // sender: one transaction; valid stays up within a burst, drops for a
  // random gap between bursts
  task automatic send(input logic act, input logic [19:0] addr, input logic [7:0] data);
    in_valid     = 1'b1;
    action       = act;
    load_address = addr;
    load_byte    = data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // nothing new is offered while waiting for the results
  task automatic wait_drained();
    in_valid = 1'b0;
    while (result_count != sent_count) @(negedge clk);
    core_pc = last_next_pc;
  endtask

  // write the word at the current pc, sometimes a stray byte, then step
  task automatic run_insn(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send(1'b0, 20'(core_pc + i), w[8*i +: 8]);
    if ($urandom_range(0, 5) == 0) send(1'b0, 20'($urandom), 8'($urandom));
    send(1'b1, 20'($urandom), 8'($urandom));
    wait_drained();
  endtask

  function automatic logic [31:0] i_type(input logic [11:0] imm, input logic [4:0] rs1,
                                         input logic [2:0] f3, input logic [4:0] rd,
                                         input logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] r_type(input logic [6:0] f7, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3,
                                         input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] s_type(input logic [11:0] imm, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] b_type(input logic [12:0] imm, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] u_type(input logic [19:0] imm, input logic [4:0] rd,
                                         input logic [6:0] op);
    return {imm, rd, op};
  endfunction

  function automatic logic [31:0] j_type(input logic [20:0] imm, input logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  // any legal non-halting instruction with random fields
  function automatic logic [31:0] random_legal_insn();
    logic [31:0] w;
    logic [4:0]  rd, rs1, rs2;
    rd  = 5'($urandom);
    rs1 = 5'($urandom);
    rs2 = 5'($urandom);
    case ($urandom_range(0, 19))
      0, 1:    w = u_type(20'($urandom), rd, OP_LUI);
      2:       w = u_type(20'($urandom), rd, OP_AUIPC);
      3:       w = j_type(21'($urandom), rd);
      4:       w = i_type(12'($urandom), rs1, 3'($urandom), rd, OP_JALR);
      5, 6, 7: w = b_type(13'($urandom), rs2, rs1, BR_F3[$urandom_range(0, 5)]);
      8, 9:    w = s_type(12'($urandom), rs2, rs1, 3'($urandom_range(0, 2)));
      10, 11:  w = i_type(12'($urandom), rs1, LD_F3[$urandom_range(0, 4)], rd, OP_LOAD);
      12, 13, 14, 15: w = i_type(12'($urandom), rs1, 3'($urandom), rd, OP_IMM);
      default: w = r_type(7'($urandom), rs2, rs1, 3'($urandom), rd);
    endcase
    if (w == HALT_WORD) w = i_type(12'h000, 5'd0, F3_ADD, 5'd0, OP_IMM);
    return w;
  endfunction

  initial begin
    logic [31:0] stop_word;
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = 1'b0;
    load_address = '0;
    load_byte    = '0;
    out_ready    = 1'b0;
    sent_count   = 0;
    core_pc      = '0;
    burst_left   = 0;
    idle_cycles  = 0;
    ready_mode   = 0;
    ready_phase  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: immediate extremes, add, sub, shifts, compares, xor, wrapping
    // misaligned memory accesses, a blt branch, jumps and a write to x0
    send(1'b0, 20'hfffff, 8'hff);
    send(1'b0, 20'h00000, 8'h00);
    wait_drained();
    run_insn(i_type(12'h800, 5'd0, F3_ADD, 5'd1, OP_IMM));
    run_insn(i_type(12'h7ff, 5'd0, F3_ADD, 5'd2, OP_IMM));
    run_insn(u_type(20'hfffff, 5'd3, OP_LUI));
    run_insn(u_type(20'h80000, 5'd4, OP_AUIPC));
    run_insn(r_type(7'h20, 5'd1, 5'd3, F3_ADD, 5'd5));
    run_insn(r_type(7'h00, 5'd2, 5'd1, F3_SLL, 5'd6));
    run_insn(r_type(7'h20, 5'd2, 5'd3, F3_SR, 5'd7));
    run_insn(i_type(12'h41f, 5'd3, F3_SR, 5'd8, OP_IMM));
    run_insn(i_type(12'h01f, 5'd3, F3_SR, 5'd9, OP_IMM));
    run_insn(r_type(7'h00, 5'd2, 5'd1, F3_SLT, 5'd11));
    run_insn(r_type(7'h00, 5'd2, 5'd1, F3_SLTU, 5'd12));
    run_insn(i_type(12'hfff, 5'd1, F3_XOR, 5'd13, OP_IMM));
    run_insn(s_type(12'hfff, 5'd3, 5'd0, F3_W));
    run_insn(i_type(12'hffe, 5'd0, F3_W, 5'd16, OP_LOAD));
    run_insn(i_type(12'hfff, 5'd0, F3_H, 5'd17, OP_LOAD));
    run_insn(b_type(13'h0008, 5'd2, 5'd1, F3_BLT));
    run_insn(j_type(21'h1ffff0, 5'd1));
    run_insn(i_type(12'h7ff, 5'd4, F3_ADD, 5'd21, OP_JALR));
    run_insn(i_type(12'h005, 5'd0, F3_ADD, 5'd0, OP_IMM));

    // random programs, written just ahead of the pc
    for (int n = 0; n < RANDOM_INSNS; n++) run_insn(random_legal_insn());

    // the core stops for good: halt with a random a0, or one of the
    // illegal encodings; afterwards steps report stopped and loads still work
    case ($urandom_range(0, 4))
      0: begin
        run_insn(i_type(12'($urandom), 5'd0, F3_ADD, REG_A0, OP_IMM));
        stop_word = HALT_WORD;
      end
      1:       stop_word = {25'($urandom), OP_UNKNOWN};
      2:       stop_word = b_type(13'($urandom), 5'($urandom), 5'($urandom), F3_BR_BAD);
      3:       stop_word = i_type(12'($urandom), 5'($urandom), F3_LD_BAD, 5'($urandom),
                                  OP_LOAD);
      default: stop_word = s_type(12'($urandom), 5'($urandom), 5'($urandom), F3_ST_BAD);
    endcase
    run_insn(stop_word);
    run_insn(random_legal_insn());
    run_insn(random_legal_insn());

    in_valid = 1'b0;
    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> rv32i_instruction_executor_core.f
hw/rtl/rv32ie_pkg.sv
hw/rtl/rv32ie_mem.sv
hw/rtl/rv32ie_regfile.sv
hw/rtl/rv32ie_alu.sv
hw/rtl/rv32i_instruction_executor_core.sv
tb/rv32i_executor_checker.sv
tb/tb_rv32i_instruction_executor_core.sv
